>>> hdl/pp_pkg.sv
// shared widths, limits and defaults for the polygon perimeter block
package pp_pkg;

  // default coordinate width, signed fixed point
  localparam int COORD_BITS_DEF = 18;

  // result field widths and saturation limits
  localparam int SIDE_W  = 19;
  localparam int PERIM_W = 29;
  localparam logic [SIDE_W-1:0]  SIDE_MAX  = {SIDE_W{1'b1}};
  localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};

  // result tdata: side length then perimeter, padded to whole bytes
  localparam int OUT_DATA_W = ((SIDE_W + PERIM_W + 7) / 8) * 8;

endpackage

>>> hdl/pp_sqrt.sv
// bit-serial restoring floor square root, one root bit per cycle
module pp_sqrt #(
  parameter int IN_W = 37
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [IN_W-1:0]         radicand,
  output logic                    done,
  output logic [(IN_W+1)/2-1:0]   root
);

  localparam int N     = (IN_W + 1) / 2;
  localparam int RAD_W = 2 * N;
  localparam int REM_W = N + 3;
  localparam int CNT_W = $clog2(N + 1);

  logic [RAD_W-1:0] rad_r;
  logic [REM_W-1:0] rem_r;
  logic [N-1:0]     root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] rem_sub;
  logic             take;

  // shift in the next two radicand bits and try the next root bit
  assign rem_sh  = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial   = REM_W'({root_r, 2'b01});
  assign rem_sub = rem_sh - trial;
  assign take    = (rem_sh >= trial);

  // control: busy for N steps, then a one-cycle done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder, root and radicand shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'(radicand);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= take ? rem_sub : rem_sh;
      root_r <= {root_r[N-2:0], take};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> hdl/polygon_perimeter.sv
// polygon perimeter: side lengths and running perimeter from streamed vertices
// a side result runs through the DIFF, SQX, SQY, GO, ROOT and EMIT states after its vertex transfer,
//   ROOT set by the bit-serial square root that yields one root bit per cycle; a lone vertex goes to EMIT
// a first vertex of a polygon frees the input at once, a later vertex only after its side is emitted,
//   a final vertex after its closing side too; in_tready low while a side is computed or emitted
// reset: synchronous active-low rst_n clears the polygon state and the result valid flag
module polygon_perimeter #(
  parameter int COORD_BITS = pp_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // vertex_x, vertex_y, zero padding
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // side_length, perimeter
  output logic [pp_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                  out_tlast
);

  localparam int CB     = COORD_BITS;
  localparam int SW     = 2 * CB + 1;
  localparam int RW     = (SW + 1) / 2;
  localparam int SIDE_W = pp_pkg::SIDE_W;
  localparam int PER_W  = pp_pkg::PERIM_W;
  localparam int EW     = (RW > SIDE_W) ? RW : SIDE_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_SQX  = 3'd2;
  localparam logic [2:0] S_SQY  = 3'd3;
  localparam logic [2:0] S_GO   = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CB-1:0]     first_x_r, first_y_r, prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic              have_first_r, last_r, closing_r;
  logic [PER_W-1:0]  perim_r;
  logic [CB-1:0]     dx_r, dy_r;
  logic [SW-1:0]     sumsq_r;
  logic [SIDE_W-1:0] side_r;
  logic              out_valid_r;
  logic [SIDE_W-1:0] out_side_r;
  logic [PER_W-1:0]  out_perim_r;
  logic              out_last_r;

  logic [CB-1:0]     in_x, in_y;
  logic              in_xfer;
  logic              slot_free;
  logic [CB-1:0]     op_ax, op_ay, op_bx, op_by;
  logic [CB:0]       diff_x, diff_y;
  logic [CB-1:0]     mag_x, mag_y;
  logic [CB-1:0]     mul_op;
  logic [2*CB-1:0]   prod;
  logic              sq_done;
  logic [RW-1:0]     sq_root;
  logic [EW-1:0]     root_ext;
  logic [SIDE_W-1:0] root_sat;
  logic [PER_W:0]    perim_add;
  logic [PER_W-1:0]  perim_new;

  assign in_x      = in_tdata[CB-1:0];
  assign in_y      = in_tdata[2*CB-1:CB];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // side end points: previous to current, or current back to first on closing
  assign op_ax = closing_r ? first_x_r : prev_x_r;
  assign op_ay = closing_r ? first_y_r : prev_y_r;
  assign op_bx = cur_x_r;
  assign op_by = cur_y_r;

  // absolute coordinate differences
  assign diff_x = $signed({op_bx[CB-1], op_bx}) - $signed({op_ax[CB-1], op_ax});
  assign diff_y = $signed({op_by[CB-1], op_by}) - $signed({op_ay[CB-1], op_ay});
  assign mag_x  = diff_x[CB] ? CB'(-diff_x) : diff_x[CB-1:0];
  assign mag_y  = diff_y[CB] ? CB'(-diff_y) : diff_y[CB-1:0];

  // shared squaring multiplier
  assign mul_op = (state_r == S_SQX) ? dx_r : dy_r;
  assign prod   = mul_op * mul_op;

  // root saturation to the side length field
  assign root_ext = EW'(sq_root);
  assign root_sat = (root_ext > EW'(pp_pkg::SIDE_MAX)) ? pp_pkg::SIDE_MAX
                                                       : root_ext[SIDE_W-1:0];

  // saturating perimeter accumulate
  assign perim_add = {1'b0, perim_r} + (PER_W+1)'(side_r);
  assign perim_new = perim_add[PER_W] ? pp_pkg::PERIM_MAX : perim_add[PER_W-1:0];

  pp_sqrt #(
    .IN_W (SW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_GO),
    .radicand (sumsq_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (have_first_r)  state_nxt = S_DIFF;
          else if (in_tlast) state_nxt = S_EMIT;
        end
      end
      S_DIFF: state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_GO;
      S_GO:   state_nxt = S_ROOT;
      S_ROOT: begin
        if (sq_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          if (!closing_r && last_r) state_nxt = S_DIFF;
          else                      state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and polygon state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_x_r    <= '0;
      first_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      have_first_r <= 1'b0;
      perim_r      <= '0;
      last_r       <= 1'b0;
      closing_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result register empties on its transfer unless a new side loads it
      if (out_valid_r && out_tready && state_r != S_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            last_r <= in_tlast;
            if (!have_first_r) begin
              first_x_r    <= in_x;
              first_y_r    <= in_y;
              prev_x_r     <= in_x;
              prev_y_r     <= in_y;
              have_first_r <= 1'b1;
              perim_r      <= '0;
              closing_r    <= in_tlast;
            end else begin
              closing_r <= 1'b0;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (closing_r) begin
              first_x_r    <= '0;
              first_y_r    <= '0;
              prev_x_r     <= '0;
              prev_y_r     <= '0;
              have_first_r <= 1'b0;
              perim_r      <= '0;
              closing_r    <= 1'b0;
            end else begin
              prev_x_r  <= cur_x_r;
              prev_y_r  <= cur_y_r;
              perim_r   <= perim_new;
              closing_r <= last_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cur_x_r <= in_x;
          cur_y_r <= in_y;
          side_r  <= '0;
        end
      end
      S_DIFF: begin
        dx_r <= mag_x;
        dy_r <= mag_y;
      end
      S_SQX: sumsq_r <= SW'(prod);
      S_SQY: sumsq_r <= sumsq_r + SW'(prod);
      S_ROOT: begin
        if (sq_done) side_r <= root_sat;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_side_r  <= side_r;
          out_perim_r <= perim_new;
          out_last_r  <= closing_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pp_pkg::OUT_DATA_W'({out_perim_r, out_side_r});
  assign out_tlast  = out_last_r;

endmodule
